/* design/slewed_delay_line_dac_macros.svh */
// ---------------------------------------------------------------------------
// slewed delay line dac assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef SLEWED_DELAY_LINE_DAC_MACROS_SVH
`define SLEWED_DELAY_LINE_DAC_MACROS_SVH

// general property, sampled on clk, off while reset is low
`define SDL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// a valid that is not taken stays up in the next cycle
`define SDL_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
    else $error(msg);

`endif

/* design/sdldac_pkg.sv */
// ---------------------------------------------------------------------------
// sdldac_pkg
// widths, reset values, register indexes and shared types of the delay dac
// ---------------------------------------------------------------------------
package sdldac_pkg;

  localparam int SampleW  = 16;
  localparam int DelayW   = 12;
  localparam int CodeW    = 12;
  localparam int CfgW     = 12;
  localparam int CfgIdxW  = 1;
  localparam int FracW    = 13;

  localparam int StoreDepthDef = 4096;

  localparam logic signed [SampleW:0] OneQ = 17'sd8192;

  localparam logic [CfgW-1:0] MidscaleRst = 12'd2048;
  localparam logic [CfgW-1:0] MaxRst      = 12'd4095;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMidscale = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMax      = 1'b1;

  typedef struct packed {
    logic [CodeW-1:0] midscale;
    logic [CodeW-1:0] max_code;
  } cfg_t;

endpackage

/* design/sdldac_if.sv */
// ---------------------------------------------------------------------------
// sdldac stream interfaces
// valid/ready channels for the sample input and the dac code output
// ---------------------------------------------------------------------------
interface sdldac_in_if import sdldac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic        [DelayW-1:0]  target_delay;

  modport source (output valid, output sample, output target_delay, input ready);
  modport sink   (input valid, input sample, input target_delay, output ready);
endinterface

interface sdldac_out_if import sdldac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] dac_code;

  modport source (output valid, output dac_code, input ready);
  modport sink   (input valid, input dac_code, output ready);
endinterface

/* design/sdldac_ram.sv */
// ---------------------------------------------------------------------------
// sdldac_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module sdldac_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read and write to one address return the old entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sdldac_conv.sv */
// ---------------------------------------------------------------------------
// sdldac_conv
// q2.13 sample to dac code: offset by one, scale by midscale, clamp
// ---------------------------------------------------------------------------
module sdldac_conv import sdldac_pkg::*; (
  input  logic signed [SampleW-1:0] sample_i,
  input  cfg_t                      cfg_i,
  output logic        [CodeW-1:0]   code_o
);

  localparam int ProdW = SampleW + 1 + CodeW + 1;

  logic signed [SampleW:0]  biased;
  logic signed [CodeW:0]    scale;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  quot;
  logic signed [ProdW-1:0]  limit;

  always_comb begin
    biased = $signed({sample_i[SampleW-1], sample_i}) + OneQ;
    scale  = $signed({1'b0, cfg_i.midscale});
    prod   = ProdW'(biased) * ProdW'(scale);
    quot   = prod >>> FracW;
    limit  = $signed({{(ProdW-CodeW){1'b0}}, cfg_i.max_code});
    if (prod <= 0) begin
      code_o = '0;
    end else if (quot >= limit) begin
      code_o = cfg_i.max_code;
    end else begin
      code_o = quot[CodeW-1:0];
    end
  end

endmodule

/* design/slewed_delay_line_dac.sv */
// ---------------------------------------------------------------------------
// slewed_delay_line_dac
// delay line of dac codes whose delay slews one sample per word to a target
// ---------------------------------------------------------------------------
// result word passes through stage one and then the output register
// throughput: one word per cycle while results are taken, limited by the single ram read and write
// an output register lets a new word in while a result waits to be taken
// reset: pointers and delay cleared, registers to defaults, then a clearing
//   pass over all StoreDepth entries zeroes the store with in ready held low
module slewed_delay_line_dac import sdldac_pkg::*; #(
  parameter int StoreDepth = StoreDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sdldac_in_if.sink          in_i,
  sdldac_out_if.source       out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int AddrW = $clog2(StoreDepth);

  function automatic logic [AddrW-1:0] ptr_next(input logic [AddrW-1:0] p);
    logic [AddrW-1:0] n;
    n = p + 1'b1;
    return (p == AddrW'(StoreDepth - 1)) ? '0 : n;
  endfunction

  cfg_t              cfg_q;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [DelayW-1:0] cur_delay_q, cur_delay_d;
  logic              clr_busy_q;
  logic [AddrW-1:0]  clr_addr_q;

  logic                      s1_valid_q;
  logic [AddrW-1:0]          s1_waddr_q;
  logic signed [SampleW-1:0] s1_sample_q;
  logic                      s1_fwd_q;
  logic [CodeW-1:0]          s1_fwd_code_q;

  logic             out_valid_q;
  logic [CodeW-1:0] out_code_q;

  logic             s1_move;
  logic             in_ready;
  logic             accept;
  logic             fwd_hit;
  logic [CodeW-1:0] conv_code;
  logic [CodeW-1:0] ram_rdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [CodeW-1:0] ram_wdata;

  assign s1_move  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !clr_busy_q && (!s1_valid_q || s1_move);
  assign accept   = in_i.valid && in_ready;

  // slew the delay one step toward the target
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cur_delay_d = cur_delay_q;
    if (in_i.target_delay > cur_delay_q) begin
      wr_ptr_d    = ptr_next(wr_ptr_q);
      cur_delay_d = cur_delay_q + 1'b1;
    end else if (in_i.target_delay < cur_delay_q) begin
      rd_ptr_d    = ptr_next(rd_ptr_q);
      cur_delay_d = cur_delay_q - 1'b1;
    end else begin
      wr_ptr_d = ptr_next(wr_ptr_q);
      rd_ptr_d = ptr_next(rd_ptr_q);
    end
  end

  // the word in stage one writes on the same edge as this read
  assign fwd_hit = s1_valid_q && (s1_waddr_q == rd_ptr_d);

  sdldac_conv u_conv (
    .sample_i (s1_sample_q),
    .cfg_i    (cfg_q),
    .code_o   (conv_code)
  );

  assign ram_we    = clr_busy_q || s1_valid_q;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_waddr_q;
  assign ram_wdata = clr_busy_q ? '0 : conv_code;

  sdldac_ram #(
    .Width (CodeW),
    .Depth (StoreDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.midscale <= MidscaleRst;
      cfg_q.max_code <= MaxRst;
      rd_ptr_q       <= '0;
      wr_ptr_q       <= '0;
      cur_delay_q    <= '0;
      clr_busy_q     <= 1'b1;
      clr_addr_q     <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMidscale: cfg_q.midscale <= cfg_data_i;
          CfgMax:      cfg_q.max_code <= cfg_data_i;
          default: ;
        endcase
      end
      if (clr_busy_q) begin
        if (clr_addr_q == AddrW'(StoreDepth - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end
      if (accept) begin
        rd_ptr_q    <= rd_ptr_d;
        wr_ptr_q    <= wr_ptr_d;
        cur_delay_q <= cur_delay_d;
        s1_valid_q  <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_waddr_q    <= wr_ptr_d;
      s1_sample_q   <= in_i.sample;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_code_q <= conv_code;
    end
    if (s1_move) begin
      out_code_q <= s1_fwd_q ? s1_fwd_code_q : ram_rdata;
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.dac_code = out_code_q;

endmodule

/* design/sdldac_checker.sv */
// ---------------------------------------------------------------------------
// sdldac_checker
// port level checks of the delay dac, bound to the top level
// ---------------------------------------------------------------------------
`include "slewed_delay_line_dac_macros.svh"

module sdldac_checker import sdldac_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CodeW-1:0] out_code_i
);

  `SDL_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, "result word dropped")
  `SDL_ASSERT(a_out_stable, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> $stable(out_code_i), "stalled code changed")
  // a fresh result word must be preceded by an accepted input word
  `SDL_ASSERT(a_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result without input word")
  // the store is still being cleared right after reset
  `SDL_ASSERT(a_clear, clk_i, rst_ni, $rose(rst_ni) |-> !in_ready_i, "input taken during clearing pass")

endmodule

bind slewed_delay_line_dac sdldac_checker u_sdldac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_code_i  (out_o.dac_code)
);
